// ===== src/ati_pkg.sv =====
// Shared types and constants of the ADC table interpolator.
// Used by the top level adc_table_interpolator; depends on nothing.
`default_nettype none

package ati_pkg;

  // Field widths.
  localparam int unsigned CODE_W   = 11;
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned PTS_W    = 7;
  localparam int unsigned OFS_W    = 10;

  // Datapath widths of the interpolation.
  localparam int unsigned DIST_W   = SAMPLE_W;            // sample - C[i]
  localparam int unsigned SEG_W    = CODE_W;              // C[i+1] - C[i]
  localparam int unsigned QUO_W    = TEMP_W;              // quotient magnitude
  localparam int unsigned PROD_W   = TEMP_W + DIST_W;     // |dT| * distance
  localparam int unsigned STEP_W   = $clog2(QUO_W);

  // APB data and address widths and register reset values.
  localparam int unsigned APB_DW       = 32;
  localparam int unsigned APB_AW       = 3;
  localparam logic [PTS_W-1:0] RESET_POINTS = 7'd53;
  localparam logic [OFS_W-1:0] RESET_OFFSET = 10'd200;

  // Register index, taken from paddr[2].
  localparam logic REG_POINTS = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  // Input commands.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_LOW    = 2'd1,
    ST_HIGH   = 2'd2,
    ST_LOADED = 2'd3
  } status_e;

  // One calibration breakpoint as stored in the table memory.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [TEMP_W-1:0] temp;
  } bp_entry_t;

endpackage

`default_nettype wire

// ===== src/ati_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; no dependencies.
`default_nettype none

module ati_ram #(
  parameter int unsigned WIDTH = 27,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/adc_table_interpolator.sv =====
// Top level of the ADC table interpolator: breakpoint memory, search, divider.
// Depends on ati_pkg and ati_ram.
// A load transfer gives its result through S_OUT; a convert transfer runs the
// one-entry-per-cycle table scan over the n searched breakpoints and, for a
// segment inside the table, the serial divider that gives one quotient bit per
// cycle. One item is in work at a time.
// Reset is asynchronous, active low; the table memory is not cleared.
`default_nettype none

module adc_table_interpolator
  import ati_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  // Configuration port.
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready,

  // Input channel.
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                cmd_i,
  input  wire logic [SLOT_W-1:0]   point_slot_i,
  input  wire logic [CODE_W-1:0]   point_code_i,
  input  wire logic [TEMP_W-1:0]   point_temp_i,
  input  wire logic [SAMPLE_W-1:0] sample_i,

  // Output channel.
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [TEMP_W-1:0]   temperature_o,
  output logic      [1:0]          status_o
);

  // AW addresses the table; NW holds a point count up to MAX_POINTS.
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned NW = $clog2(MAX_POINTS + 1);

  // The scan walks the table in S_SEARCH. A segment inside the table reads its
  // upper breakpoint in S_NEXT, forms the differences in S_DIFF, multiplies in
  // S_MUL, divides one quotient bit per cycle in S_DIV and adds the base
  // temperature in S_FIX. S_OUT waits for the output register to be free.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_NEXT,
    S_DIFF,
    S_MUL,
    S_DIV,
    S_FIX,
    S_OUT
  } state_e;

  state_e              state_q;

  // Configuration registers.
  logic [PTS_W-1:0]    points_q;
  logic [OFS_W-1:0]    offset_q;

  // Item context.
  logic [SAMPLE_W-1:0] sample_q;
  logic [NW-1:0]       n_q;
  logic [NW-1:0]       cnt_q;
  logic                found_q;
  logic [AW-1:0]       idx_q;
  logic [CODE_W-1:0]   c0_q;
  logic [TEMP_W-1:0]   t0_q;
  logic [TEMP_W-1:0]   tfirst_q;

  // Interpolation datapath.
  logic                neg_q;
  logic [QUO_W-1:0]    mag_q;
  logic [DIST_W-1:0]   dist_q;
  logic [SEG_W-1:0]    width_q;
  logic [SEG_W-1:0]    rem_q;
  logic [QUO_W-1:0]    dvd_q;
  logic [STEP_W-1:0]   step_q;

  // Result and output register.
  logic [TEMP_W-1:0]   base_q;
  status_e             res_status_q;
  logic                out_valid_q;
  logic [TEMP_W-1:0]   out_temp_q;
  status_e             out_status_q;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes must happen only while the block is idle; it does
  // not enforce this. The registers are sampled straight into the datapath.
  // ---------------------------------------------------------------------------
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_POINTS: prdata = APB_DW'(points_q);
      REG_OFFSET: prdata = APB_DW'(offset_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= RESET_POINTS;
      offset_q <= RESET_OFFSET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_POINTS: points_q <= pwdata[PTS_W-1:0];
        REG_OFFSET: offset_q <= pwdata[OFS_W-1:0];
        default:    points_q <= points_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Breakpoint table. Writes happen only in S_IDLE and reads only outside it,
  // so a read and a write of the same entry never overlap.
  // ---------------------------------------------------------------------------
  logic      in_xfer;
  logic      ram_we;
  logic      ram_re;
  logic [AW-1:0] ram_raddr;
  bp_entry_t ram_wdata;
  bp_entry_t ram_rdata;
  logic [$bits(bp_entry_t)-1:0] ram_rdata_raw;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // Loads to slots past the end of the table are answered but not stored.
  assign ram_we          = in_xfer && (cmd_i == CMD_LOAD)
                           && (32'(point_slot_i) < MAX_POINTS);
  assign ram_wdata.code  = point_code_i;
  assign ram_wdata.temp  = point_temp_i;
  assign ram_re          = ((state_q == S_SEARCH) && (cnt_q < n_q)) || (state_q == S_NEXT);
  assign ram_raddr       = (state_q == S_NEXT) ? AW'(idx_q + AW'(1)) : cnt_q[AW-1:0];
  assign ram_rdata       = bp_entry_t'(ram_rdata_raw);

  ati_ram #(
    .WIDTH ($bits(bp_entry_t)),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(point_slot_i)),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  // ---------------------------------------------------------------------------
  // Combinational helpers for each state.
  // ---------------------------------------------------------------------------

  // Clamp the searched point count to the range 2 .. MAX_POINTS.
  logic [NW-1:0] n_start;
  always_comb begin
    if (points_q < PTS_W'(2)) begin
      n_start = NW'(2);
    end else if (32'(points_q) > MAX_POINTS) begin
      n_start = NW'(MAX_POINTS);
    end else begin
      n_start = NW'(points_q);
    end
  end

  // Scan: the entry read last cycle belongs to index cnt_q - 1. A hit is an
  // entry whose code is not above the sample; the last hit wins.
  logic          hit;
  logic          found_now;
  logic [NW-1:0] cnt_m1;
  assign cnt_m1    = cnt_q - NW'(1);
  assign hit       = (cnt_q != '0) && (ram_rdata.code <= CODE_W'(sample_q));
  assign found_now = found_q || hit;

  // Segment differences from the lower breakpoint (registered) and the upper
  // one (memory output). The upper code is above the sample, so width > 0.
  logic [TEMP_W:0] dt;
  assign dt = {1'b0, ram_rdata.temp} - {1'b0, t0_q};

  // One restoring division step.
  logic [SEG_W:0] rem_sh;
  logic           q_bit;
  assign rem_sh = {rem_q, dvd_q[QUO_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, width_q});

  // Base plus signed quotient, clamped to the temperature range.
  logic signed [TEMP_W+1:0] t_sum;
  assign t_sum = neg_q ? ($signed({2'b00, t0_q}) - $signed({2'b00, dvd_q}))
                       : ($signed({2'b00, t0_q}) + $signed({2'b00, dvd_q}));

  // Final offset add with saturation.
  logic [TEMP_W:0] off_sum;
  assign off_sum = {1'b0, base_q} + (TEMP_W+1)'(offset_q);

  // ---------------------------------------------------------------------------
  // Sequencer and datapath registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sample_q     <= '0;
      n_q          <= '0;
      cnt_q        <= '0;
      found_q      <= 1'b0;
      idx_q        <= '0;
      c0_q         <= '0;
      t0_q         <= '0;
      tfirst_q     <= '0;
      neg_q        <= 1'b0;
      mag_q        <= '0;
      dist_q       <= '0;
      width_q      <= '0;
      rem_q        <= '0;
      dvd_q        <= '0;
      step_q       <= '0;
      base_q       <= '0;
      res_status_q <= ST_INTERP;
      out_valid_q  <= 1'b0;
      out_temp_q   <= '0;
      out_status_q <= ST_INTERP;
    end else begin
      // In S_OUT the output register is refilled below instead.
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (cmd_i == CMD_LOAD) begin
              base_q       <= '0;
              res_status_q <= ST_LOADED;
              state_q      <= S_OUT;
            end else begin
              sample_q <= sample_i;
              n_q      <= n_start;
              cnt_q    <= '0;
              found_q  <= 1'b0;
              state_q  <= S_SEARCH;
            end
          end
        end

        S_SEARCH: begin
          if (cnt_q == NW'(1)) begin
            tfirst_q <= ram_rdata.temp;
          end
          if (hit) begin
            found_q <= 1'b1;
            idx_q   <= cnt_m1[AW-1:0];
            c0_q    <= ram_rdata.code;
            t0_q    <= ram_rdata.temp;
          end
          if (cnt_q == n_q) begin
            // Last entry evaluated: decide between clamping and interpolation.
            if (!found_now) begin
              base_q       <= tfirst_q;
              res_status_q <= ST_LOW;
              state_q      <= S_OUT;
            end else if (hit) begin
              // The last searched breakpoint is the segment start.
              base_q       <= ram_rdata.temp;
              res_status_q <= (CODE_W'(sample_q) > ram_rdata.code) ? ST_HIGH : ST_INTERP;
              state_q      <= S_OUT;
            end else begin
              state_q <= S_NEXT;
            end
          end else begin
            cnt_q <= cnt_q + NW'(1);
          end
        end

        S_NEXT: begin
          state_q <= S_DIFF;
        end

        S_DIFF: begin
          neg_q   <= dt[TEMP_W];
          mag_q   <= dt[TEMP_W] ? QUO_W'(-dt) : dt[QUO_W-1:0];
          dist_q  <= sample_q - c0_q[DIST_W-1:0];
          width_q <= ram_rdata.code - c0_q;
          state_q <= S_MUL;
        end

        S_MUL: begin
          // The distance is below the width, so the high product bits are
          // already below the divisor and the quotient fits QUO_W bits.
          rem_q   <= SEG_W'(({(PROD_W)'(mag_q)} * (PROD_W)'(dist_q)) >> QUO_W);
          dvd_q   <= QUO_W'((PROD_W)'(mag_q) * (PROD_W)'(dist_q));
          step_q  <= '0;
          state_q <= S_DIV;
        end

        S_DIV: begin
          rem_q  <= q_bit ? SEG_W'(rem_sh - {1'b0, width_q}) : rem_sh[SEG_W-1:0];
          dvd_q  <= {dvd_q[QUO_W-2:0], q_bit};
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(QUO_W - 1)) begin
            state_q <= S_FIX;
          end
        end

        S_FIX: begin
          if (t_sum < 0) begin
            base_q <= '0;
          end else if (t_sum > $signed((TEMP_W+2)'({TEMP_W{1'b1}}))) begin
            base_q <= '1;
          end else begin
            base_q <= t_sum[TEMP_W-1:0];
          end
          res_status_q <= ST_INTERP;
          state_q      <= S_OUT;
        end

        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            if (res_status_q == ST_LOADED) begin
              out_temp_q <= '0;
            end else if (off_sum[TEMP_W]) begin
              out_temp_q <= '1;
            end else begin
              out_temp_q <= off_sum[TEMP_W-1:0];
            end
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign temperature_o = out_temp_q;
  assign status_o      = out_status_q;

`ifndef SYNTHESIS
  // A load result never carries a temperature.
  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_LOADED)) |-> (temperature_o == '0))
    else $error("load result with nonzero temperature");

  // The scan never runs past the searched point count.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (cnt_q <= n_q))
    else $error("table scan past point count");

  // The partial remainder stays below the divisor through the division.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < width_q))
    else $error("division remainder not below segment width");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench of adc_table_interpolator: calibration table loads and conversions.
// Every result is checked against an interpolation predictor kept inside this bench.
// Depends on ati_pkg and the RTL of adc_table_interpolator.
`timescale 1ns / 1ps

module testbench;
  import ati_pkg::*;

  localparam int TABLE_DEPTH    = 64;
  localparam int ITEM_GOAL      = 600;
  localparam int IDLE_PERCENT   = 19;
  // No transfer for this many cycles means the block hung. Even the slowest conversion
  // with a long output stall stays far below this.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int REPORT_LIMIT   = 10;
  localparam int SAMPLE_MAX     = 1023;
  localparam int CODE_MAX       = 2047;
  localparam int TEMP_MAX       = 65535;
  localparam int OFFSET_MAX     = 1023;
  localparam int POINTS_MAX     = 127;

  typedef struct packed {
    logic                cmd;
    logic [SLOT_W-1:0]   slot;
    logic [CODE_W-1:0]   code;
    logic [TEMP_W-1:0]   temp;
    logic [SAMPLE_W-1:0] sample;
  } cal_item_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic [1:0]        status;
  } reading_t;

  // Clock, reset and everything the bench drives start at known values.
  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [APB_AW-1:0]   paddr        = '0;
  logic [APB_DW-1:0]   pwdata       = '0;
  logic                in_valid_i   = 1'b0;
  logic                cmd_i        = 1'b0;
  logic [SLOT_W-1:0]   point_slot_i = '0;
  logic [CODE_W-1:0]   point_code_i = '0;
  logic [TEMP_W-1:0]   point_temp_i = '0;
  logic [SAMPLE_W-1:0] sample_i     = '0;
  logic                out_ready_i  = 1'b0;

  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [TEMP_W-1:0]   temperature_o;
  logic [1:0]          status_o;

  // Predictor state: its own copy of the breakpoint table and of both registers.
  int          cal_code [TABLE_DEPTH];
  int          cal_temp [TABLE_DEPTH];
  int unsigned cfg_points = RESET_POINTS;
  int unsigned cfg_offset = RESET_OFFSET;

  // Readings still owed by the block, oldest first.
  reading_t    pending_readings [$];

  logic        no_idle = 1'b0;
  int unsigned items_sent, results_checked, failures, stall_cycles, table_setups;
  int unsigned loads_done, converts_done, low_clamps, high_clamps, saturated;

  adc_table_interpolator #(
    .MAX_POINTS(TABLE_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .point_slot_i (point_slot_i),
    .point_code_i (point_code_i),
    .point_temp_i (point_temp_i),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .temperature_o(temperature_o),
    .status_o     (status_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // The result side stalls at random, except during the stretch without idling.
  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  function automatic void log_failure(string msg);
    if (failures < REPORT_LIMIT) begin
      $display("%s", msg);
    end
    failures++;
  endfunction

  // Applies one item to the predictor and returns the reading it must produce.
  // Loads update the table; conversions search the first n slots for the last
  // code not above the sample and interpolate toward the next breakpoint, or clamp.
  function automatic reading_t predict_reading(cal_item_t it);
    reading_t r;
    int       n, idx, raw, sum, sample;
    bit       found;
    longint   t0, dt, seg_off, width, q, t;
    r.temperature = '0;
    r.status      = ST_LOADED;
    if (it.cmd == CMD_LOAD) begin
      if (it.slot < TABLE_DEPTH) begin
        cal_code[it.slot] = it.code;
        cal_temp[it.slot] = it.temp;
      end
      loads_done++;
      return r;
    end
    converts_done++;
    // Out-of-range point counts act as the nearest legal count.
    n = (cfg_points < 2) ? 2 : (cfg_points > TABLE_DEPTH) ? TABLE_DEPTH : cfg_points;
    sample = it.sample;
    idx    = 0;
    found  = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (cal_code[i] <= sample) begin
        idx   = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      raw      = cal_temp[0];
      r.status = ST_LOW;
      low_clamps++;
    end else if (idx == n - 1) begin
      // A sample equal to the last code still counts as interpolated.
      raw      = cal_temp[idx];
      r.status = (sample > cal_code[idx]) ? ST_HIGH : ST_INTERP;
      if (sample > cal_code[idx]) begin
        high_clamps++;
      end
    end else begin
      t0      = cal_temp[idx];
      dt      = longint'(cal_temp[idx + 1]) - t0;
      seg_off = longint'(sample) - longint'(cal_code[idx]);
      width   = longint'(cal_code[idx + 1]) - longint'(cal_code[idx]);
      // Signed division truncates toward zero, also for falling segments.
      q     = (width > 0) ? (dt * seg_off) / width : 0;
      t     = t0 + q;
      if (t < 0) begin
        t = 0;
      end
      if (t > TEMP_MAX) begin
        t = TEMP_MAX;
      end
      raw      = int'(t);
      r.status = ST_INTERP;
    end
    sum = raw + int'(cfg_offset);
    if (sum > TEMP_MAX) begin
      r.temperature = TEMP_W'(TEMP_MAX);
      saturated++;
    end else begin
      r.temperature = TEMP_W'(sum);
    end
    return r;
  endfunction

  function automatic int random_temp();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return TEMP_MAX;
      default: return int'($urandom_range(0, TEMP_MAX));
    endcase
  endfunction

  // Register writes: setup cycle, then access cycle; the register takes the value
  // at the access edge. The bus then goes quiet before the next access.
  task automatic write_reg(input logic reg_idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({reg_idx, 2'b00});
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_POINTS) begin
      cfg_points = value & 32'h7F;
    end else begin
      cfg_offset = value & 32'h3FF;
    end
    @(posedge clk_i);
  endtask

  task automatic check_reg(input logic reg_idx, input int unsigned want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_AW'({reg_idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== APB_DW'(want)) begin
      log_failure($sformatf("register %0d read: expected %0d, got %0d", reg_idx, want, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_regs();
    check_reg(REG_POINTS, cfg_points);
    check_reg(REG_OFFSET, cfg_offset);
  endtask

  // Presents one item and holds it until the transfer; the expected reading is
  // queued at the accepting edge. Valid is only dropped while idling or draining, so
  // back-to-back items keep it high without a glitch.
  task automatic send_item(input cal_item_t it);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= it.cmd;
    point_slot_i <= it.slot;
    point_code_i <= it.code;
    point_temp_i <= it.temp;
    sample_i     <= it.sample;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_readings.push_back(predict_reading(it));
    items_sent++;
  endtask

  // The fields a command does not use carry random values; the block must ignore them.
  task automatic send_load(input int slot, input int code, input int temp);
    cal_item_t it;
    it.cmd    = CMD_LOAD;
    it.slot   = SLOT_W'(slot);
    it.code   = CODE_W'(code);
    it.temp   = TEMP_W'(temp);
    it.sample = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    send_item(it);
  endtask

  task automatic send_convert(input int sample);
    cal_item_t it;
    it.cmd    = CMD_CONVERT;
    it.slot   = SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
    it.code   = CODE_W'($urandom_range(0, CODE_MAX));
    it.temp   = TEMP_W'($urandom_range(0, TEMP_MAX));
    it.sample = SAMPLE_W'(sample);
    send_item(it);
  endtask

  // Stops sending and waits until every owed reading has been transferred.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_readings.size() != 0);
  endtask

  // Each result transfer is compared with the oldest owed reading.
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_readings.size() == 0) begin
        log_failure($sformatf("unexpected result: temperature %0d status %0d",
                              temperature_o, status_o));
      end else begin
        want = pending_readings.pop_front();
        if (temperature_o !== want.temperature || status_o !== want.status) begin
          log_failure($sformatf(
              "result %0d: expected temperature %0d status %0d, got temperature %0d status %0d",
              results_checked, want.temperature, want.status, temperature_o, status_o));
        end
      end
      results_checked++;
    end
  end

  // Watchdog: too long without any transfer on either channel ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", stall_cycles);
      $display("[adc_table_interpolator] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Reset values, then both registers at their extremes, read back each time.
  task automatic test_register_access();
    check_regs();
    write_reg(REG_POINTS, POINTS_MAX);
    write_reg(REG_OFFSET, OFFSET_MAX);
    check_regs();
    write_reg(REG_POINTS, 0);
    write_reg(REG_OFFSET, 0);
    check_regs();
  endtask

  // Two-point tables with point counts below the minimum: below and above the table,
  // a sample on the last code, a falling segment, extreme codes and temperatures,
  // and saturation of the offset sum.
  task automatic test_two_point_table();
    wait_drained();
    write_reg(REG_POINTS, 1);
    write_reg(REG_OFFSET, OFFSET_MAX);
    send_load(0, 100, 1000);
    send_load(1, 900, 64000);
    send_convert(0);
    send_convert(SAMPLE_MAX);
    send_convert(900);
    send_convert(100);
    send_convert(517);
    wait_drained();
    write_reg(REG_POINTS, 0);
    send_load(1, CODE_MAX, 0);
    send_convert(SAMPLE_MAX);
    send_convert(101);
    send_load(0, 0, TEMP_MAX);
    send_convert(0);
    send_load(1, SAMPLE_MAX, TEMP_MAX);
    send_convert(SAMPLE_MAX);
    send_convert(511);
  endtask

  // Codes out of order: the search still takes the last slot not above the sample.
  task automatic test_unordered_table();
    wait_drained();
    write_reg(REG_POINTS, 3);
    write_reg(REG_OFFSET, 0);
    send_load(0, 500, 3000);
    send_load(1, 200, 100);
    send_load(2, 800, 9000);
    send_convert(100);
    send_convert(300);
    send_convert(600);
    send_convert(900);
    send_convert(500);
  endtask

  // Random table setups: pick a point count and offset while idle, load a complete
  // table (mostly ascending), then convert samples aimed at its segments, with a few
  // stray loads that disturb the table.
  task automatic test_random_tables();
    int pts, eff, ofs, span, step, start, pick, j, sample, conv_count;
    bit ordered;
    while (items_sent < ITEM_GOAL) begin
      table_setups++;
      pick = $urandom_range(0, 9);
      case (pick)
        0: pts = $urandom_range(0, 1);
        1: pts = $urandom_range(TABLE_DEPTH + 1, POINTS_MAX);
        2: pts = TABLE_DEPTH;
        3: pts = $urandom_range(9, TABLE_DEPTH - 1);
        default: pts = $urandom_range(2, 8);
      endcase
      // The first setups force the widest table and the narrowest legal one.
      if (table_setups == 1) begin
        pts = POINTS_MAX;
      end else if (table_setups == 2) begin
        pts = 2;
      end
      eff = (pts < 2) ? 2 : (pts > TABLE_DEPTH) ? TABLE_DEPTH : pts;
      case ($urandom_range(0, 3))
        0: ofs = 0;
        1: ofs = OFFSET_MAX;
        default: ofs = $urandom_range(0, OFFSET_MAX);
      endcase

      wait_drained();
      write_reg(REG_POINTS, pts);
      write_reg(REG_OFFSET, ofs);
      if (table_setups == 4) begin
        check_regs();
      end
      // A long stretch without any idling on either side.
      no_idle <= (table_setups == 3 || table_setups == 4);

      ordered = ($urandom_range(0, 7) != 0);
      span    = ($urandom_range(0, 7) == 0) ? 1980 : 1100;
      step    = span / eff;
      start   = $urandom_range(0, 60);
      for (int i = 0; i < eff; i++) begin
        send_load(i, ordered ? start + i * step + int'($urandom_range(0, step - 1))
                             : int'($urandom_range(0, CODE_MAX)), random_temp());
      end

      conv_count = $urandom_range(15, 40);
      for (int k = 0; k < conv_count; k++) begin
        // Once, hold the input back until the block has answered everything.
        if (table_setups == 2 && k == conv_count / 2) begin
          wait_drained();
        end
        pick = $urandom_range(0, 19);
        j    = $urandom_range(0, eff - 1);
        if (pick == 0) begin
          send_load($urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, CODE_MAX),
                    random_temp());
        end else begin
          if (pick < 4) begin
            sample = $urandom_range(0, SAMPLE_MAX);
          end else if (pick < 7) begin
            sample = cal_code[j];
          end else if (pick < 9) begin
            sample = cal_code[0] - int'($urandom_range(1, 8));
          end else begin
            sample = cal_code[j] + int'($urandom_range(0, step));
          end
          if (sample < 0) begin
            sample = 0;
          end
          if (sample > SAMPLE_MAX) begin
            sample = SAMPLE_MAX;
          end
          send_convert(sample);
        end
      end
      no_idle <= 1'b0;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_two_point_table();
    test_unordered_table();
    test_random_tables();

    // Let any stray result show up before the verdict.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d breakpoint loads and %0d conversions over %0d random table setups.",
             loads_done, converts_done, table_setups);
    $display("Conversions: %0d clamped low, %0d clamped high, %0d saturated; %0d failures.",
             low_clamps, high_clamps, saturated, failures);
    if (failures == 0) begin
      $display("[adc_table_interpolator] OK");
    end else begin
      $display("[adc_table_interpolator] ERROR");
    end
    $finish;
  end

endmodule
